@@ design/mtcmp_pkg.sv @@
package mtcmp_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [15:0] ADDR_TIME_LO = 16'd0;
	localparam logic [15:0] ADDR_TIME_HI = 16'd4;
	localparam logic [15:0] ADDR_CMP_LO  = 16'd8;
	localparam logic [15:0] ADDR_CMP_HI  = 16'd12;

	localparam logic [31:0] TIMER_CAUSE = 32'h8000_0007;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_ADDR_ERR = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [31:0] write_data;
		logic [2:0]  access_bytes;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        status;
		logic        irq_valid;
		logic [31:0] irq_cause;
	} out_item_t;

	// Byte lanes moved by an access; sizes above four count as four.
	function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
		logic [31:0] m;
		case (nbytes)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00FF;
			3'd2: m = 32'h0000_FFFF;
			3'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

@@ design/mtcmp_in_reg.sv @@
module mtcmp_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtcmp_pkg::in_item_t in_item,
	input  logic                out_stall,
	output logic                advance,
	output mtcmp_pkg::in_item_t item_s1
);
	import mtcmp_pkg::*;

	logic valid_s1;

	// The held item moves on whenever the result register can take it.
	assign advance  = valid_s1 && !out_stall;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ design/mtcmp_core.sv @@
module mtcmp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  mtcmp_pkg::in_item_t  item_s1,
	output mtcmp_pkg::out_item_t result
);
	import mtcmp_pkg::*;

	logic [63:0] time_count_q;
	logic [63:0] time_snapshot_q;
	logic [63:0] compare_value_q;
	logic        irq_armed_q;

	logic [63:0] count_d;
	logic [63:0] snap_d;
	logic [63:0] cmp_d;
	logic        armed_d;
	logic        armed_upd;
	logic [31:0] mask;
	logic [31:0] wdata;
	logic [31:0] rdata;
	logic        status;
	logic        fire;

	always_comb begin
		mask      = byte_mask(item_s1.access_bytes);
		wdata     = item_s1.write_data & mask;
		count_d   = time_count_q;
		snap_d    = time_snapshot_q;
		cmp_d     = compare_value_q;
		armed_upd = irq_armed_q;
		rdata     = 32'd0;
		status    = STATUS_OK;

		case (item_s1.cmd)
			CMD_READ: begin
				if (item_s1.addr == ADDR_TIME_LO) begin
					snap_d = time_count_q;
					rdata  = time_count_q[31:0];
				end else if (item_s1.addr == ADDR_TIME_HI) begin
					rdata = time_snapshot_q[63:32];
				end else if (item_s1.addr == ADDR_CMP_LO) begin
					rdata = compare_value_q[31:0];
				end else if (item_s1.addr == ADDR_CMP_HI) begin
					rdata = compare_value_q[63:32];
				end else begin
					status = STATUS_ADDR_ERR;
				end
				rdata = rdata & mask;
			end
			CMD_WRITE: begin
				if (item_s1.addr == ADDR_TIME_LO) begin
					count_d[31:0] = wdata;
					snap_d[31:0]  = wdata;
				end else if (item_s1.addr == ADDR_TIME_HI) begin
					count_d[63:32] = wdata;
					snap_d[63:32]  = wdata;
				end else if (item_s1.addr == ADDR_CMP_LO) begin
					cmp_d[31:0] = wdata;
				end else if (item_s1.addr == ADDR_CMP_HI) begin
					cmp_d[63:32] = wdata;
					armed_upd    = 1'b1;
				end else begin
					status = STATUS_ADDR_ERR;
				end
			end
			CMD_TICK: begin
				count_d = time_count_q + 64'd1;
			end
			default: begin
			end
		endcase

		// The compare is made on the state this item leaves behind.
		fire    = armed_upd && (count_d == cmp_d);
		armed_d = armed_upd && !fire;

		result.read_data = rdata;
		result.status    = status;
		result.irq_valid = fire;
		result.irq_cause = fire ? TIMER_CAUSE : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_count_q    <= 64'd0;
			time_snapshot_q <= 64'd0;
			compare_value_q <= 64'd0;
			irq_armed_q     <= 1'b0;
		end else if (advance) begin
			time_count_q    <= count_d;
			time_snapshot_q <= snap_d;
			compare_value_q <= cmp_d;
			irq_armed_q     <= armed_d;
		end
	end

endmodule

@@ design/mtcmp_out_reg.sv @@
module mtcmp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  mtcmp_pkg::out_item_t result,
	output logic                 out_stall,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mtcmp_pkg::out_item_t out_item
);
	import mtcmp_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign out_stall = valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item <= result;
		end
	end

endmodule

@@ design/machine_timer_compare_irq_unit.sv @@
// Machine timer with a 64-bit count and compare behind four 32-bit bus words.
// Input channel (in_valid, in_ready, in_item) carries a bus read, a bus write
// or one time tick; every item gives exactly one result on the output channel
// (out_valid, out_ready, out_item) with read data, status and interrupt flag.
// Reading time low snapshots the count; reading time high returns the top half
// of that snapshot. Writing compare high arms a one-shot interrupt that fires,
// with the machine timer cause, on the first result whose item leaves the
// count equal to the compare value.
// The item sits in the input register while decode, count update and the 64-bit
// compare feed the result register; out_valid rises when that register takes the
// result. One item is taken every cycle while the receiver keeps out_ready high;
// the 64-bit increment and equality compare set the cycle.
// When the receiver stalls, the result register holds its item; the input register
// takes one more item only if it is empty, and in_ready is low while it holds one.
// Reset clears count, snapshot, compare value and the armed flag, and empties
// both registers.
module machine_timer_compare_irq_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mtcmp_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mtcmp_pkg::out_item_t out_item
);
	import mtcmp_pkg::*;

	in_item_t  item_s1;
	out_item_t result;
	logic      advance;
	logic      out_stall;

	mtcmp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_stall (out_stall),
		.advance   (advance),
		.item_s1   (item_s1)
	);

	mtcmp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	mtcmp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
